@@ rtl/core/stop_and_wait_arq_rtt_timer_unit_macros.svh @@
// Assertion macros for the stop-and-wait ARQ timer unit.
`ifndef STOP_AND_WAIT_ARQ_RTT_TIMER_UNIT_MACROS_SVH
`define STOP_AND_WAIT_ARQ_RTT_TIMER_UNIT_MACROS_SVH

// Check that cond_a implies cond_c in the same cycle, outside reset.
`define SAWRT_ASSERT_IMPLIES(label, cond_a, cond_c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_c)) \
        else $error("sawrt implication check failed");

// Check that expr never holds, outside reset.
`define SAWRT_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sawrt forbidden condition seen");

`endif

@@ rtl/core/sawrt_pkg.sv @@
// Shared types, constants and helpers for the stop-and-wait ARQ timer unit.
`timescale 1ns / 1ps

package sawrt_pkg;

    localparam int TIME_BITS_DEF = 16;
    localparam int SEQ_BITS_DEF  = 32;

    localparam int EST_W   = 16;
    localparam int INRTT_W = 14;
    localparam int INDEV_W = 12;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;

    localparam logic [EST_W-1:0]   MAX_TIMEOUT_RST = 16'd5000;
    localparam logic [INRTT_W-1:0] INIT_RTT_RST    = 14'd500;
    localparam logic [INDEV_W-1:0] INIT_DEV_RST    = 12'd50;

    // Q16 smoothing gains
    localparam logic [EST_W-1:0] GAIN_DEV_OLD = 16'd45875;
    localparam logic [EST_W-1:0] GAIN_DEV_NEW = 16'd19661;
    localparam logic [EST_W-1:0] GAIN_RTT_OLD = 16'd52429;
    localparam logic [EST_W-1:0] GAIN_RTT_NEW = 16'd13107;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_DATA = 2'd2,
        OP_TICK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ACT_TRANSMIT   = 2'd0,
        ACT_RETRANSMIT = 2'd1,
        ACT_SEND_ACK   = 2'd2,
        ACT_ACKED      = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        REG_MAX_TIMEOUT = 2'd0,
        REG_INIT_RTT    = 2'd1,
        REG_INIT_DEV    = 2'd2,
        REG_NONE        = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic                 load;
        logic [INRTT_W-1:0]   rtt;
        logic [INDEV_W-1:0]   dev;
    } init_load_t;

    typedef struct packed {
        logic awaiting;
        logic retx;
    } ctrl_status_t;

    typedef struct packed {
        act_t             action;
        logic             deliver;
        logic [EST_W-1:0] rtt;
        logic [EST_W-1:0] dev;
        logic [EST_W-1:0] timeout;
    } result_t;

    // rtt + 4*dev, saturated to the estimate width
    function automatic logic [EST_W-1:0] timeout_from(input logic [EST_W-1:0] r,
                                                       input logic [EST_W-1:0] d);
        logic [EST_W+1:0] sum;
        sum = {2'b00, r} + {d, 2'b00};
        return (sum[EST_W+1:EST_W] != 2'b00) ? {EST_W{1'b1}} : sum[EST_W-1:0];
    endfunction

endpackage

@@ rtl/core/sawrt_estimator.sv @@
// RTT and deviation update for one sample, plus the derived timeout.
`timescale 1ns / 1ps

module sawrt_estimator (
    input  logic                     first,
    input  logic [sawrt_pkg::EST_W-1:0] sample,
    input  logic [sawrt_pkg::EST_W-1:0] rtt,
    input  logic [sawrt_pkg::EST_W-1:0] dev,
    output logic [sawrt_pkg::EST_W-1:0] rtt_new,
    output logic [sawrt_pkg::EST_W-1:0] dev_new,
    output logic [sawrt_pkg::EST_W-1:0] timeout_new
);
    import sawrt_pkg::*;

    localparam int PROD_W = 2 * EST_W;

    logic [EST_W-1:0]  diff;
    logic [PROD_W:0]   dev_sum;
    logic [PROD_W:0]   rtt_sum;
    logic [EST_W:0]    dev_q;
    logic [EST_W:0]    rtt_q;

    always_comb
    begin
        diff    = (sample > rtt) ? (sample - rtt) : (rtt - sample);
        dev_sum = {1'b0, PROD_W'(GAIN_DEV_OLD) * PROD_W'(dev)}
                + {1'b0, PROD_W'(GAIN_DEV_NEW) * PROD_W'(diff)};
        rtt_sum = {1'b0, PROD_W'(GAIN_RTT_OLD) * PROD_W'(rtt)}
                + {1'b0, PROD_W'(GAIN_RTT_NEW) * PROD_W'(sample)};
        // truncate the Q16 fraction
        dev_q   = dev_sum[PROD_W:EST_W];
        rtt_q   = rtt_sum[PROD_W:EST_W];
        if (first)
        begin
            rtt_new = sample;
            dev_new = {1'b0, sample[EST_W-1:1]};
        end
        else
        begin
            rtt_new = rtt_q[EST_W] ? {EST_W{1'b1}} : rtt_q[EST_W-1:0];
            dev_new = dev_q[EST_W] ? {EST_W{1'b1}} : dev_q[EST_W-1:0];
        end
        timeout_new = timeout_from(rtt_new, dev_new);
    end

endmodule

@@ rtl/core/sawrt_ctrl.sv @@
// Protocol state: sequence numbers, timer, estimates and per-beat result.
`timescale 1ns / 1ps

module sawrt_ctrl #(
    parameter int TIME_BITS = sawrt_pkg::TIME_BITS_DEF,
    parameter int SEQ_BITS  = sawrt_pkg::SEQ_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         proc_en,
    input  sawrt_pkg::op_t               op,
    input  logic [SEQ_BITS-1:0]          pn,
    input  logic [sawrt_pkg::EST_W-1:0]  max_timeout,
    input  sawrt_pkg::init_load_t        init,
    output logic                         res_valid,
    output sawrt_pkg::result_t           res,
    output logic [SEQ_BITS-1:0]          res_number,
    output sawrt_pkg::ctrl_status_t      status
);
    import sawrt_pkg::*;

    localparam int CMP_W = (TIME_BITS > EST_W) ? TIME_BITS : EST_W;
    localparam logic [EST_W-1:0] RTT_RST = EST_W'(INIT_RTT_RST);
    localparam logic [EST_W-1:0] DEV_RST = EST_W'(INIT_DEV_RST);

    logic [SEQ_BITS-1:0]  send_reg, send_next;
    logic [SEQ_BITS-1:0]  expect_reg, expect_next;
    logic [EST_W-1:0]     rtt_reg, rtt_next;
    logic [EST_W-1:0]     dev_reg, dev_next;
    logic [EST_W-1:0]     timeout_reg, timeout_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic                 awaiting_reg, awaiting_next;
    logic                 retx_reg, retx_next;

    logic [CMP_W-1:0]     elapsed_ext;
    logic [TIME_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]     elapsed_inc_ext;
    logic [EST_W-1:0]     sample;
    logic [EST_W:0]       doubled;
    logic [EST_W-1:0]     est_rtt;
    logic [EST_W-1:0]     est_dev;
    logic [EST_W-1:0]     est_timeout;

    always_comb
    begin
        elapsed_ext     = CMP_W'(elapsed_reg);
        sample          = (elapsed_ext > CMP_W'({EST_W{1'b1}})) ? {EST_W{1'b1}}
                                                               : elapsed_ext[EST_W-1:0];
        // saturating timer
        elapsed_inc     = (elapsed_reg == {TIME_BITS{1'b1}}) ? elapsed_reg
                                                             : elapsed_reg + 1'b1;
        elapsed_inc_ext = CMP_W'(elapsed_inc);
        doubled         = {timeout_reg, 1'b0};
    end

    sawrt_estimator u_est (
        .first       (send_reg == '0),
        .sample      (sample),
        .rtt         (rtt_reg),
        .dev         (dev_reg),
        .rtt_new     (est_rtt),
        .dev_new     (est_dev),
        .timeout_new (est_timeout)
    );

    always_comb
    begin
        send_next     = send_reg;
        expect_next   = expect_reg;
        rtt_next      = rtt_reg;
        dev_next      = dev_reg;
        timeout_next  = timeout_reg;
        elapsed_next  = elapsed_reg;
        awaiting_next = awaiting_reg;
        retx_next     = retx_reg;
        res_valid     = 1'b0;
        res.action    = ACT_TRANSMIT;
        res.deliver   = 1'b0;
        res_number    = send_reg;

        if (init.load)
        begin
            rtt_next     = EST_W'(init.rtt);
            dev_next     = EST_W'(init.dev);
            timeout_next = timeout_from(EST_W'(init.rtt), EST_W'(init.dev));
        end
        else if (proc_en)
        begin
            unique case (op)
                OP_SEND:
                begin
                    awaiting_next = 1'b1;
                    retx_next     = 1'b0;
                    elapsed_next  = '0;
                    res_valid     = 1'b1;
                    res.action    = ACT_TRANSMIT;
                end
                OP_ACK:
                begin
                    if (awaiting_reg && (pn == send_reg))
                    begin
                        // only clean round trips feed the estimator
                        if (!retx_reg)
                        begin
                            rtt_next     = est_rtt;
                            dev_next     = est_dev;
                            timeout_next = est_timeout;
                        end
                        send_next     = send_reg + 1'b1;
                        awaiting_next = 1'b0;
                        retx_next     = 1'b0;
                        elapsed_next  = '0;
                        res_valid     = 1'b1;
                        res.action    = ACT_ACKED;
                    end
                end
                OP_DATA:
                begin
                    res_valid  = 1'b1;
                    res.action = ACT_SEND_ACK;
                    if (pn == expect_reg)
                    begin
                        expect_next = expect_reg + 1'b1;
                        res.deliver = 1'b1;
                        res_number  = pn;
                    end
                    else
                    begin
                        // re-ack the last in-order number
                        res_number = expect_reg - 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (awaiting_reg)
                    begin
                        if (elapsed_inc_ext >= CMP_W'(timeout_reg))
                        begin
                            timeout_next = (doubled > {1'b0, max_timeout}) ? max_timeout
                                                                           : doubled[EST_W-1:0];
                            retx_next    = 1'b1;
                            elapsed_next = '0;
                            res_valid    = 1'b1;
                            res.action   = ACT_RETRANSMIT;
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.rtt     = rtt_next;
        res.dev     = dev_next;
        res.timeout = timeout_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_reg     <= '0;
            expect_reg   <= '0;
            rtt_reg      <= RTT_RST;
            dev_reg      <= DEV_RST;
            timeout_reg  <= timeout_from(RTT_RST, DEV_RST);
            elapsed_reg  <= '0;
            awaiting_reg <= 1'b0;
            retx_reg     <= 1'b0;
        end
        else
        begin
            send_reg     <= send_next;
            expect_reg   <= expect_next;
            rtt_reg      <= rtt_next;
            dev_reg      <= dev_next;
            timeout_reg  <= timeout_next;
            elapsed_reg  <= elapsed_next;
            awaiting_reg <= awaiting_next;
            retx_reg     <= retx_next;
        end
    end

    assign status.awaiting = awaiting_reg;
    assign status.retx     = retx_reg;

endmodule

@@ rtl/core/stop_and_wait_arq_rtt_timer_unit.sv @@
// Top level: stream ports, APB registers, input and result registers.
//
//  channel   dir   handshake          payload
//  s_*       in    s_tvalid/s_tready  s_tuser operation, s_tdata packet_number
//  m_*       out   m_tvalid/m_tready  m_tuser action, m_tdata number/deliver/estimates
//  apb       in    psel/penable       paddr, pwdata, prdata (pready tied high)
//
// One beat per cycle sustained while m_tready stays high; a result passes through the input
// register, then the state update and the result register.
// Reset loads the estimates from the register reset values; no sweep is needed.
// A stalled m_tready holds the result register; s_tready drops once the input
// register is also full. Beats that cause no result (stale ack, idle tick) drain.
`timescale 1ns / 1ps
`include "stop_and_wait_arq_rtt_timer_unit_macros.svh"

module stop_and_wait_arq_rtt_timer_unit #(
    parameter int TIME_BITS = sawrt_pkg::TIME_BITS_DEF,
    parameter int SEQ_BITS  = sawrt_pkg::SEQ_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // [31:0] packet_number
    input  logic [1:0]                    s_tuser,  // [1:0] operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] number_out, [32] deliver, [48:33] rtt_estimate,
    // [64:49] deviation_estimate, [80:65] timeout_ms, [87:81] zero
    output logic [87:0]                   m_tdata,
    output logic [1:0]                    m_tuser,  // [1:0] action
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sawrt_pkg::ADDR_W-1:0]  paddr,
    input  logic [sawrt_pkg::DATA_W-1:0]  pwdata,
    output logic [sawrt_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import sawrt_pkg::*;

    // configuration registers
    logic [EST_W-1:0]   max_timeout_reg;
    logic [INRTT_W-1:0] init_rtt_reg, init_rtt_next;
    logic [INDEV_W-1:0] init_dev_reg, init_dev_next;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;
    init_load_t         init;

    // input register
    logic                in_valid_reg;
    op_t                 in_op_reg;
    logic [SEQ_BITS-1:0] in_pn_reg;

    // result register
    logic                out_valid_reg;
    result_t             out_res_reg;
    logic [SEQ_BITS-1:0] out_num_reg;

    logic                can_advance;
    logic                proc_en;
    logic                res_valid;
    result_t             res;
    logic [SEQ_BITS-1:0] res_number;
    ctrl_status_t        status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        init_rtt_next = init_rtt_reg;
        init_dev_next = init_dev_reg;
        init.load     = 1'b0;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_INIT_RTT:
                begin
                    init_rtt_next = pwdata[INRTT_W-1:0];
                    init.load     = 1'b1;
                end
                REG_INIT_DEV:
                begin
                    init_dev_next = pwdata[INDEV_W-1:0];
                    init.load     = 1'b1;
                end
                REG_MAX_TIMEOUT, REG_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
        init.rtt = init_rtt_next;
        init.dev = init_dev_next;
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MAX_TIMEOUT: prdata = DATA_W'(max_timeout_reg);
            REG_INIT_RTT:    prdata = DATA_W'(init_rtt_reg);
            REG_INIT_DEV:    prdata = DATA_W'(init_dev_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_timeout_reg <= MAX_TIMEOUT_RST;
            init_rtt_reg    <= INIT_RTT_RST;
            init_dev_reg    <= INIT_DEV_RST;
        end
        else
        begin
            if (cfg_wr && (cfg_idx == REG_MAX_TIMEOUT))
            begin
                max_timeout_reg <= pwdata[EST_W-1:0];
            end
            init_rtt_reg <= init_rtt_next;
            init_dev_reg <= init_dev_next;
        end
    end

    assign can_advance = !out_valid_reg || m_tready;
    assign proc_en     = in_valid_reg && can_advance;
    assign s_tready    = !in_valid_reg || can_advance;

    sawrt_ctrl #(
        .TIME_BITS (TIME_BITS),
        .SEQ_BITS  (SEQ_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .proc_en     (proc_en),
        .op          (in_op_reg),
        .pn          (in_pn_reg),
        .max_timeout (max_timeout_reg),
        .init        (init),
        .res_valid   (res_valid),
        .res         (res),
        .res_number  (res_number),
        .status      (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_en)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc_en)
            begin
                out_valid_reg <= res_valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg <= op_t'(s_tuser);
            in_pn_reg <= s_tdata[SEQ_BITS-1:0];
        end
        if (proc_en && res_valid)
        begin
            out_res_reg <= res;
            out_num_reg <= res_number;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.action;
    assign m_tdata  = {7'b0, out_res_reg.timeout, out_res_reg.dev, out_res_reg.rtt,
                       out_res_reg.deliver, 32'(out_num_reg)};

    `SAWRT_ASSERT_IMPLIES(a_deliver_only_on_ack, m_tvalid && m_tdata[32], m_tuser == ACT_SEND_ACK)
    `SAWRT_ASSERT_IMPLIES(a_empty_out_takes_in, !m_tvalid, s_tready)
    `SAWRT_ASSERT_IMPLIES(a_retx_result_state, m_tvalid && (m_tuser == ACT_RETRANSMIT),
                          status.awaiting && status.retx)
    `SAWRT_ASSERT_NEVER(a_retx_needs_pending, !status.awaiting && status.retx)

endmodule

@@ tb/stop_and_wait_arq_rtt_timer_unit_test.sv @@
// Self-checking testbench for the stop-and-wait ARQ timer unit with a predicted result stream.
`timescale 1ns / 1ps

module stop_and_wait_arq_rtt_timer_unit_test;
    import sawrt_pkg::*;

    typedef struct {
        op_t         op;
        logic [31:0] num;
    } arq_input_t;

    typedef struct {
        act_t        action;
        logic [31:0] number;
        logic        deliver;
        logic [15:0] rtt;
        logic [15:0] dev;
        logic [15:0] rto;
    } arq_report_t;

    // Q16 smoothing gains
    localparam logic [63:0] DEV_KEEP = 64'd45875;
    localparam logic [63:0] DEV_GAIN = 64'd19661;
    localparam logic [63:0] RTT_KEEP = 64'd52429;
    localparam logic [63:0] RTT_GAIN = 64'd13107;
    localparam int HOLD_CYCLES = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    // predicted block state and registers
    logic [31:0] send_seq = '0;
    logic [31:0] recv_seq = '0;
    logic [15:0] rtt_ms = 16'd500;
    logic [15:0] dev_ms = 16'd50;
    logic [15:0] rto_ms = 16'd700;
    logic [15:0] timer_ms = '0;
    logic [15:0] cap_ms = 16'd5000;
    logic [13:0] start_rtt = 14'd500;
    logic [11:0] start_dev = 12'd50;
    bit          outstanding = 1'b0;
    bit          resent = 1'b0;

    // stimulus planning state, tracked as the queue is filled
    logic [31:0] plan_sn = '0;
    logic [31:0] plan_en = '0;
    bit          plan_waiting = 1'b0;
    int          planned = 0;
    int          ops_issued = 0;

    arq_input_t  pending_ops[$];
    arq_report_t expected_actions[$];
    arq_input_t  next_item;
    arq_input_t  in_item;
    arq_report_t want;
    arq_report_t want_out;

    int          beats_in = 0;
    int          results_out = 0;
    int          errors = 0;
    int          seen_by_action[4] = '{0, 0, 0, 0};
    int          send_gap = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;
    bit          hold_off = 1'b0;
    bit          squeeze_start = 1'b0;

    stop_and_wait_arq_rtt_timer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] clip16(input logic [63:0] v);
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] timeout_of(input logic [15:0] r, input logic [15:0] d);
        return clip16({48'd0, r} + {46'd0, d, 2'b00});
    endfunction

    function automatic arq_report_t pack_report(input act_t a, input logic [31:0] n,
                                                input logic d);
        arq_report_t rep;
        rep.action  = a;
        rep.number  = n;
        rep.deliver = d;
        rep.rtt     = rtt_ms;
        rep.dev     = dev_ms;
        rep.rto     = rto_ms;
        return rep;
    endfunction

    // Advance the predicted state by one beat; return 1 when it yields a result.
    function automatic bit arq_step(input arq_input_t item, output arq_report_t rep);
        logic [15:0] sample;
        logic [15:0] diff;
        logic [63:0] d_acc;
        logic [63:0] r_acc;
        logic [16:0] doubled;
        rep = pack_report(ACT_TRANSMIT, '0, 1'b0);
        case (item.op)
            OP_SEND: begin
                outstanding = 1'b1;
                resent = 1'b0;
                timer_ms = '0;
                rep = pack_report(ACT_TRANSMIT, send_seq, 1'b0);
                return 1'b1;
            end
            OP_ACK: begin
                if (!outstanding || item.num != send_seq)
                    return 1'b0;
                // Karn's rule: no sample from a retransmitted packet
                if (!resent) begin
                    sample = timer_ms;
                    if (send_seq == '0) begin
                        rtt_ms = sample;
                        dev_ms = sample >> 1;
                    end else begin
                        diff = (sample > rtt_ms) ? sample - rtt_ms : rtt_ms - sample;
                        d_acc = (DEV_KEEP * {48'd0, dev_ms} + DEV_GAIN * {48'd0, diff}) >> 16;
                        r_acc = (RTT_KEEP * {48'd0, rtt_ms} + RTT_GAIN * {48'd0, sample}) >> 16;
                        dev_ms = clip16(d_acc);
                        rtt_ms = clip16(r_acc);
                    end
                    rto_ms = timeout_of(rtt_ms, dev_ms);
                end
                rep = pack_report(ACT_ACKED, send_seq, 1'b0);
                send_seq = send_seq + 32'd1;
                outstanding = 1'b0;
                resent = 1'b0;
                timer_ms = '0;
                return 1'b1;
            end
            OP_DATA: begin
                if (item.num == recv_seq) begin
                    recv_seq = recv_seq + 32'd1;
                    rep = pack_report(ACT_SEND_ACK, item.num, 1'b1);
                end else begin
                    rep = pack_report(ACT_SEND_ACK, recv_seq - 32'd1, 1'b0);
                end
                return 1'b1;
            end
            default: begin
                if (!outstanding)
                    return 1'b0;
                if (timer_ms != 16'hFFFF)
                    timer_ms = timer_ms + 16'd1;
                if (timer_ms >= rto_ms) begin
                    doubled = {rto_ms, 1'b0};
                    if (doubled > {1'b0, cap_ms})
                        doubled = {1'b0, cap_ms};
                    rto_ms = doubled[15:0];
                    resent = 1'b1;
                    timer_ms = '0;
                    rep = pack_report(ACT_RETRANSMIT, send_seq, 1'b0);
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        errors++;
        if (errors <= 40)
            $display("MISMATCH result %0d %s: got %0h, predicted %0h",
                     results_out, what, got, exp_val);
    endtask

    // Queue one beat and keep the planning view of sequence numbers in step.
    function automatic void push_op(input op_t op, input logic [31:0] num);
        arq_input_t item;
        item.op  = op;
        item.num = num;
        pending_ops.push_back(item);
        ops_issued++;
        case (op)
            OP_SEND: begin
                plan_waiting = 1'b1;
                planned++;
            end
            OP_ACK: begin
                if (plan_waiting && num == plan_sn) begin
                    plan_sn = plan_sn + 32'd1;
                    plan_waiting = 1'b0;
                    planned++;
                end
            end
            OP_DATA: begin
                if (num == plan_en)
                    plan_en = plan_en + 32'd1;
                planned++;
            end
            default: begin
                if (plan_waiting)
                    planned++;
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_data_number();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return plan_en;
        if (sel < 8)
            return plan_en - 32'd1;
        return $urandom;
    endfunction

    // Mostly complete send/tick/ack exchanges, with data arrivals and stray beats mixed in.
    task automatic queue_flows(input int target, input int tick_span);
        int goal;
        int pick;
        int k;
        goal = planned + target;
        while (planned < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                push_op(OP_SEND, $urandom);
                k = $urandom_range(0, tick_span);
                repeat (k) begin
                    if ($urandom_range(0, 9) == 0)
                        push_op(OP_DATA, pick_data_number());
                    push_op(OP_TICK, $urandom);
                end
                if ($urandom_range(0, 5) == 0)
                    push_op(OP_ACK, plan_sn ^ (32'd1 << $urandom_range(0, 31)));
                // leave the packet outstanding now and then
                if ($urandom_range(0, 9) != 0)
                    push_op(OP_ACK, plan_sn);
            end else if (pick < 80) begin
                push_op(OP_DATA, pick_data_number());
            end else if (pick < 87) begin
                push_op(OP_ACK, $urandom);
            end else if (pick < 94) begin
                push_op(OP_TICK, $urandom);
            end else begin
                push_op(OP_SEND, $urandom);
            end
        end
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MAX_TIMEOUT) begin
            cap_ms = value[15:0];
        end else if (idx == REG_INIT_RTT || idx == REG_INIT_DEV) begin
            if (idx == REG_INIT_RTT)
                start_rtt = value[13:0];
            else
                start_dev = value[11:0];
            rtt_ms = {2'b00, start_rtt};
            dev_ms = {4'h0, start_dev};
            rto_ms = timeout_of(rtt_ms, dev_ms);
        end
    endtask

    // Wait until every queued beat is taken and every predicted result has come back.
    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((beats_in != ops_issued || expected_actions.size() != 0) && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        // let beats that yield no result drain through the pipeline
        repeat (4) @(posedge clk);
    endtask

    // input side: drive beats and predict on each accepted one
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_item.op  = op_t'(s_tuser);
                in_item.num = s_tdata;
                if (arq_step(in_item, want))
                    expected_actions.push_back(want);
                beats_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(0, 3);
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    next_item = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_item.op;
                    s_tdata  <= next_item.num;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: random backpressure
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (hold_off) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            seen_by_action[m_tuser]++;
            if (expected_actions.size() == 0) begin
                report_mismatch("result with nothing predicted", {30'd0, m_tuser}, '0);
            end else begin
                want_out = expected_actions.pop_front();
                if (m_tuser != want_out.action)
                    report_mismatch("action", {30'd0, m_tuser}, {30'd0, want_out.action});
                if (m_tdata[31:0] != want_out.number)
                    report_mismatch("number_out", m_tdata[31:0], want_out.number);
                if (m_tdata[32] != want_out.deliver)
                    report_mismatch("deliver", {31'd0, m_tdata[32]}, {31'd0, want_out.deliver});
                if (m_tdata[48:33] != want_out.rtt)
                    report_mismatch("rtt_estimate", {16'd0, m_tdata[48:33]}, {16'd0, want_out.rtt});
                if (m_tdata[64:49] != want_out.dev)
                    report_mismatch("deviation_estimate", {16'd0, m_tdata[64:49]},
                                    {16'd0, want_out.dev});
                if (m_tdata[80:65] != want_out.rto)
                    report_mismatch("timeout_ms", {16'd0, m_tdata[80:65]}, {16'd0, want_out.rto});
                if (m_tdata[87:81] != '0)
                    report_mismatch("tdata pad", {25'd0, m_tdata[87:81]}, '0);
            end
            results_out++;
        end
    end

    // Hold the receiver off long enough for the block to fill and stall its input.
    initial begin
        wait (squeeze_start);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: idle beats, data ordering, first sample seeding
        push_op(OP_TICK, 32'h0);
        push_op(OP_ACK, 32'h0);
        push_op(OP_DATA, 32'd5);
        push_op(OP_DATA, 32'd0);
        push_op(OP_DATA, 32'hFFFF_FFFF);
        push_op(OP_SEND, 32'hFFFF_FFFF);
        repeat (3) push_op(OP_TICK, 32'hFFFF_FFFF);
        push_op(OP_DATA, 32'd1);
        push_op(OP_ACK, 32'h8000_0000);
        push_op(OP_TICK, 32'h0);
        push_op(OP_ACK, 32'd0);
        push_op(OP_SEND, 32'h0);
        push_op(OP_TICK, 32'h0);
        push_op(OP_SEND, 32'h5555_AAAA);
        repeat (2) push_op(OP_TICK, 32'h0);
        push_op(OP_ACK, 32'd1);
        push_op(OP_TICK, 32'h0);
        wait_idle();

        // small timeouts so expiry and backoff come often
        write_reg(REG_MAX_TIMEOUT, 32'd40);
        write_reg(REG_INIT_RTT, 32'd4);
        write_reg(REG_INIT_DEV, 32'd1);
        queue_flows(350, 30);
        wait_idle();

        // zero timeout: every tick expires, doubling stays at zero
        write_reg(REG_MAX_TIMEOUT, 32'd1);
        write_reg(REG_INIT_RTT, 32'd0);
        write_reg(REG_INIT_DEV, 32'd0);
        push_op(OP_SEND, $urandom);
        repeat (2) push_op(OP_TICK, $urandom);
        push_op(OP_ACK, plan_sn);
        push_op(OP_SEND, $urandom);
        push_op(OP_ACK, plan_sn);
        queue_flows(140, 3);
        wait_idle();

        // one millisecond timeout against a one millisecond cap
        write_reg(REG_INIT_RTT, 32'd1);
        push_op(OP_SEND, $urandom);
        repeat (2) push_op(OP_TICK, $urandom);
        push_op(OP_ACK, plan_sn);
        queue_flows(60, 4);
        wait_idle();

        // full-scale estimates, then a burst of data beats under a long receiver stall
        write_reg(REG_MAX_TIMEOUT, 32'd65535);
        write_reg(REG_INIT_RTT, 32'd16383);
        write_reg(REG_INIT_DEV, 32'd4095);
        push_op(OP_SEND, $urandom);
        repeat (5) push_op(OP_TICK, $urandom);
        push_op(OP_ACK, plan_sn);
        repeat (100) push_op(OP_DATA, pick_data_number());
        push_op(OP_SEND, $urandom);
        push_op(OP_ACK, plan_sn);
        squeeze_start = 1'b1;
        wait_idle();

        // a write outside the register map must change nothing
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        write_reg(REG_MAX_TIMEOUT, 32'd20);
        write_reg(REG_INIT_RTT, 32'd2);
        write_reg(REG_INIT_DEV, 32'd3);
        queue_flows(300, 25);
        wait_idle();

        // closing stretch at full rate on both sides
        write_reg(REG_MAX_TIMEOUT, 32'd100);
        write_reg(REG_INIT_RTT, 32'd10);
        write_reg(REG_INIT_DEV, 32'd0);
        @(posedge clk);
        quiet <= 1'b1;
        queue_flows(350, 40);
        wait_idle();

        if (expected_actions.size() != 0)
            report_mismatch("results never delivered", expected_actions.size(), '0);
        $display("Checked %0d input beats and %0d results: %0d transmit, %0d retransmit,",
                 beats_in, results_out, seen_by_action[ACT_TRANSMIT],
                 seen_by_action[ACT_RETRANSMIT]);
        $display("%0d ack sent, %0d acknowledged, across seven register settings.",
                 seen_by_action[ACT_SEND_ACK], seen_by_action[ACT_ACKED]);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/sawrt_pkg.sv
rtl/core/sawrt_estimator.sv
rtl/core/sawrt_ctrl.sv
rtl/core/stop_and_wait_arq_rtt_timer_unit.sv
tb/stop_and_wait_arq_rtt_timer_unit_test.sv
